/* rtl/plr_pkg.sv */
// Shared types and constants for the piecewise-linear ramp lookup.
// No dependencies; every other file of the block imports this package.
package plr_pkg;

  localparam int DEF_MAX_STOPS = 8;   // default table depth
  localparam int POS_W         = 24;  // signed Q16.8 position
  localparam int CHAN_W        = 16;  // Q1.15 channel
  localparam int NCHAN         = 4;   // red, green, blue, alpha
  localparam int IDX_W         = 3;   // stop_index field
  localparam int CNT_W         = 4;   // stop count register
  localparam int FRAC_W        = 16;  // Q0.16 interpolation fraction

  // 1.0 in Q0.16, one bit wider than the fraction
  localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CL_INTERP = 2'd0,
    CL_LOW    = 2'd1,
    CL_HIGH   = 2'd2
  } clamp_t;

  // element 0 is red, 3 is alpha
  typedef logic [NCHAN-1:0][CHAN_W-1:0] chans_t;

  // one classified request on its way from front to back
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] pos;   // stop position or query point
    chans_t                  vals;
  } qent_t;

endpackage

/* rtl/plr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on plr_pkg for default sizes only.
module plr_ram import plr_pkg::*; #(
  parameter int WIDTH = POS_W,
  parameter int DEPTH = DEF_MAX_STOPS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/plr_fifo.sv */
// Two-entry request queue between the front and back parts.
// Depends on plr_pkg (qent_t).
module plr_fifo import plr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t din,
  output logic  full,
  input  logic  pop,
  output qent_t dout,
  output logic  empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/plr_front.sv */
// Front part: registers incoming requests, classifies load/query and
// drops loads aimed past the table. Depends on plr_pkg.
module plr_front import plr_pkg::*; #(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [IDX_W-1:0]        stop_index,
  input  logic signed [POS_W-1:0] stop_position,
  input  logic [CHAN_W-1:0]       value_red,
  input  logic [CHAN_W-1:0]       value_green,
  input  logic [CHAN_W-1:0]       value_blue,
  input  logic [CHAN_W-1:0]       value_alpha,
  input  logic signed [POS_W-1:0] query_point,
  output logic                    push,
  output qent_t                   ent,
  input  logic                    full
);

  logic ent_valid;
  logic accept;
  logic keep;

  // out-of-range loads are swallowed here
  assign keep     = (op_t'(opcode) == OP_QUERY) || (int'(stop_index) < MAX_STOPS);
  assign in_stall = ent_valid && full;
  assign accept   = in_valid && !in_stall;
  assign push     = ent_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (accept) begin
      ent_valid <= keep;
    end else if (push) begin
      ent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent.op   <= op_t'(opcode);
      ent.idx  <= stop_index;
      ent.pos  <= (op_t'(opcode) == OP_QUERY) ? query_point : stop_position;
      ent.vals <= {value_alpha, value_blue, value_green, value_red};
    end
  end

endmodule

/* rtl/plr_back.sv */
// Back part: owns the stop table and the stop count register, executes loads
// and runs the query sequencer (scan, serial divide, serial multiply) into the
// output register. Depends on plr_pkg and plr_ram.
module plr_back import plr_pkg::*; #(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             q_valid,
  input  qent_t            q_ent,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output chans_t           out_chans,
  output clamp_t           out_code
);

  localparam int AW        = $clog2(MAX_STOPS);
  localparam int VAL_W     = NCHAN * CHAN_W;
  localparam int DIV_STEPS = FRAC_W + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int MUL_STEPS = 2 * NCHAN;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
  localparam int CH_W      = $clog2(NCHAN);
  localparam int PROD_W    = CHAN_W + FRAC_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_FETCH = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        stops_used;
  int                      cnt_eff;
  logic [AW-1:0]           last_idx;
  logic                    out_load;

  // table ports
  logic                    tbl_we;
  logic [AW-1:0]           tbl_waddr;
  logic [AW-1:0]           pos_raddr;
  logic [AW-1:0]           val_raddr;
  logic [POS_W-1:0]        pos_rdata;
  chans_t                  val_rdata;

  // query working registers
  logic signed [POS_W-1:0] t_pt;
  logic signed [POS_W-1:0] prev_pos;
  logic signed [POS_W-1:0] pos_rd;
  logic [AW-1:0]           chk;
  logic [AW-1:0]           sel_idx;
  clamp_t                  code;
  logic                    ge;
  logic signed [POS_W:0]   num_s;
  logic signed [POS_W:0]   den_s;

  // divider
  logic [POS_W:0]          rem;
  logic [POS_W-1:0]        den_r;
  logic [FRAC_W:0]         quot;
  logic [DCNT_W-1:0]       dcnt;
  logic [POS_W+1:0]        diff;
  logic                    qbit;
  logic [POS_W-1:0]        kept;

  // multiplier
  chans_t                  va;
  chans_t                  vb;
  chans_t                  res;
  logic [FRAC_W:0]         frac;
  logic [FRAC_W:0]         wa;
  logic [MCNT_W-1:0]       mcnt;
  logic [MCNT_W-1:0]       km1;
  logic [CH_W-1:0]         ch;
  logic [CHAN_W-1:0]       mx;
  logic [FRAC_W:0]         mw;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       acc;
  logic [PROD_W:0]         sum;

  plr_ram #(.WIDTH(POS_W), .DEPTH(MAX_STOPS)) u_pos_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (q_ent.pos),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  plr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_STOPS)) u_val_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (q_ent.vals),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // stops in use, limited to 1..MAX_STOPS
  always_comb begin
    cnt_eff = int'(stops_used);
    if (cnt_eff < 1) begin
      cnt_eff = 1;
    end
    if (cnt_eff > MAX_STOPS) begin
      cnt_eff = MAX_STOPS;
    end
    last_idx = AW'(cnt_eff - 1);
  end

  assign tbl_waddr = AW'(q_ent.idx);
  assign pos_rd    = pos_rdata;
  assign ge        = (pos_rd >= t_pt);
  assign num_s     = {t_pt[POS_W-1], t_pt} - {prev_pos[POS_W-1], prev_pos};
  assign den_s     = {pos_rd[POS_W-1], pos_rd} - {prev_pos[POS_W-1], prev_pos};

  // restoring divide step
  assign diff = {1'b0, rem} - {2'b00, den_r};
  assign qbit = !diff[POS_W+1];
  assign kept = qbit ? diff[POS_W-1:0] : rem[POS_W-1:0];

  // weights
  assign frac = (quot > FRAC_ONE) ? FRAC_ONE : quot;
  assign wa   = FRAC_ONE - frac;

  // multiply schedule: even steps va * (1 - f), odd steps vb * f
  assign ch  = mcnt[CH_W:1];
  assign mx  = mcnt[0] ? vb[ch] : va[ch];
  assign mw  = mcnt[0] ? frac : wa;
  assign km1 = mcnt - 1'b1;
  assign sum = {1'b0, acc} + {1'b0, prod};

  // finished result moves into the output register
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    q_pop     = 1'b0;
    tbl_we    = 1'b0;
    pos_raddr = '0;
    val_raddr = '0;
    case (state)
      ST_IDLE: begin
        q_pop  = q_valid;
        tbl_we = q_valid && (q_ent.op == OP_LOAD);
      end
      ST_SCAN: begin
        pos_raddr = chk + 1'b1;
        val_raddr = (ge && (chk != '0)) ? chk - 1'b1 : chk;
      end
      ST_DIV: begin
        val_raddr = sel_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      stops_used <= CNT_W'(1);
    end else begin
      if (cfg_wr_en) begin
        stops_used <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && (q_ent.op == OP_QUERY)) begin
            t_pt  <= q_ent.pos;
            chk   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ge && (chk == '0)) begin
            code  <= CL_LOW;
            state <= ST_FETCH;
          end else if (ge) begin
            code    <= CL_INTERP;
            rem     <= {1'b0, num_s[POS_W-1:0]};
            den_r   <= den_s[POS_W-1:0];
            sel_idx <= chk;
            dcnt    <= '0;
            state   <= ST_DIV;
          end else if (chk == last_idx) begin
            code  <= CL_HIGH;
            state <= ST_FETCH;
          end else begin
            prev_pos <= pos_rd;
            chk      <= chk + 1'b1;
          end
        end
        ST_FETCH: begin
          res   <= val_rdata;
          state <= ST_OUT;
        end
        ST_DIV: begin
          if (dcnt == DCNT_W'(0)) begin
            va <= val_rdata;
          end
          if (dcnt == DCNT_W'(1)) begin
            vb <= val_rdata;
          end
          rem  <= {kept, 1'b0};
          quot <= {quot[FRAC_W-1:0], qbit};
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            mcnt  <= '0;
            state <= ST_MUL;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        ST_MUL: begin
          prod <= PROD_W'(mx) * PROD_W'(mw);
          if (mcnt != '0) begin
            if (!km1[0]) begin
              acc <= prod;
            end else begin
              res[km1[CH_W:1]] <= sum[CHAN_W+FRAC_W-1:FRAC_W];
            end
          end
          if (mcnt == MCNT_W'(MUL_STEPS)) begin
            state <= ST_OUT;
          end else begin
            mcnt <= mcnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_chans <= res;
            out_code  <= code;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/piecewise_linear_ramp_lookup_top.sv */
// A query passes the front register and the two-entry queue, which overlap with the back
// part; the back part scans from one to all stops in use, one position RAM read a cycle,
// then fetches the clamped end stop or runs the serial divider and serial multiplier. The
// back part executes a load while idle and can take the next request at once; a query holds
// it until its result enters the output register, which out_stall can delay.
// Reset (rst, synchronous): control cleared, stop count = 1, stop table undefined.
module piecewise_linear_ramp_lookup_top import plr_pkg::*; #(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration: number of stops in use
  input  logic                    cfg_wr_en,
  input  logic [CNT_W-1:0]        cfg_wr_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [IDX_W-1:0]        stop_index,
  input  logic signed [POS_W-1:0] stop_position,
  input  logic [CHAN_W-1:0]       value_red,
  input  logic [CHAN_W-1:0]       value_green,
  input  logic [CHAN_W-1:0]       value_blue,
  input  logic [CHAN_W-1:0]       value_alpha,
  input  logic signed [POS_W-1:0] query_point,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAN_W-1:0]       out_red,
  output logic [CHAN_W-1:0]       out_green,
  output logic [CHAN_W-1:0]       out_blue,
  output logic [CHAN_W-1:0]       out_alpha,
  output logic [1:0]              clamped_end
);

  // front -> queue
  logic   f_push;
  qent_t  f_ent;
  logic   q_full;
  // queue -> back
  qent_t  q_ent;
  logic   q_empty;
  logic   q_pop;
  // result register
  chans_t out_chans;
  clamp_t out_code;

  // Front: one request register; out-of-range loads die here.
  plr_front #(.MAX_STOPS(MAX_STOPS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .stop_index    (stop_index),
    .stop_position (stop_position),
    .value_red     (value_red),
    .value_green   (value_green),
    .value_blue    (value_blue),
    .value_alpha   (value_alpha),
    .query_point   (query_point),
    .push          (f_push),
    .ent           (f_ent),
    .full          (q_full)
  );

  // Loads travel through the queue too, so table writes stay ordered with queries.
  plr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_ent),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_ent),
    .empty (q_empty)
  );

  // Back: table, sequencer and the output register; it keeps dequeuing while a result
  // in the output register waits on out_stall, until its next query result is finished.
  plr_back #(.MAX_STOPS(MAX_STOPS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (!q_empty),
    .q_ent       (q_ent),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_chans   (out_chans),
    .out_code    (out_code)
  );

  assign out_red     = out_chans[0];
  assign out_green   = out_chans[1];
  assign out_blue    = out_chans[2];
  assign out_alpha   = out_chans[3];
  assign clamped_end = out_code;

endmodule

/* rtl/plr_checker.sv */
// Port-level checks for the ramp lookup top level, attached by bind.
// Depends on plr_pkg and piecewise_linear_ramp_lookup_top.
module plr_checker import plr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] clamped_end
);

  // queries accepted but not yet answered
  logic [3:0] pend;
  logic       q_acc;
  logic       o_acc;

  assign q_acc = in_valid && !in_stall && (op_t'(opcode) == OP_QUERY);
  assign o_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      case ({q_acc, o_acc})
        2'b10:   pend <= pend + 1'b1;
        2'b01:   pend <= pend - 1'b1;
        default: pend <= pend;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pend != '0))
    else $error("result without an outstanding query");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clamped_end != 2'd3))
    else $error("illegal clamped_end code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind piecewise_linear_ramp_lookup_top plr_checker u_plr_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for piecewise_linear_ramp_lookup_top: a stop table, loads and ramp queries.
// Depends on rtl/plr_pkg.sv (types, widths, op and clamp codes) and the top module of the block.
module tb_top;
  import plr_pkg::*;

  localparam int     TBL_DEPTH    = DEF_MAX_STOPS;
  localparam int     ITEMS_TOTAL  = 2000;    // requests queued, directed part included
  localparam int     DRAIN_CYCLES = 100;     // wait after the last result so trailing loads finish inside the block
  localparam int     HOLD_CYCLES  = 800;     // long receiver hold-off to back the block up
  localparam longint RUN_LIMIT    = 64'd10_000_000;  // simulation time limit, far above a slow run

  // one request as offered on the input channel
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] pos;
    chans_t                  vals;
    logic signed [POS_W-1:0] point;
  } ramp_req_t;

  // one ramp result: four channels and the clamp code
  typedef struct packed {
    chans_t chans;
    clamp_t code;
  } ramp_out_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]        cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    opcode = 1'b0;
  logic [IDX_W-1:0]        stop_index = '0;
  logic signed [POS_W-1:0] stop_position = '0;
  logic [CHAN_W-1:0]       value_red = '0;
  logic [CHAN_W-1:0]       value_green = '0;
  logic [CHAN_W-1:0]       value_blue = '0;
  logic [CHAN_W-1:0]       value_alpha = '0;
  logic signed [POS_W-1:0] query_point = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CHAN_W-1:0]       out_red;
  logic [CHAN_W-1:0]       out_green;
  logic [CHAN_W-1:0]       out_blue;
  logic [CHAN_W-1:0]       out_alpha;
  logic [1:0]              clamped_end;

  chans_t out_chans;
  assign out_chans = {out_alpha, out_blue, out_green, out_red};

  piecewise_linear_ramp_lookup_top #(
    .MAX_STOPS(TBL_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .stop_index   (stop_index),
    .stop_position(stop_position),
    .value_red    (value_red),
    .value_green  (value_green),
    .value_blue   (value_blue),
    .value_alpha  (value_alpha),
    .query_point  (query_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .clamped_end  (clamped_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: stop table and stop count, updated as requests are
  // accepted, so every query sees exactly the table the block saw.
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] tbl_pos [TBL_DEPTH];
  chans_t                  tbl_val [TBL_DEPTH];
  logic [CNT_W-1:0]        ramp_count = 4'd1;   // reset value of the stop count register

  ramp_req_t req_pending_q [$];   // requests waiting for the driver
  ramp_out_t ramp_expect_q [$];   // predicted ramp results, oldest first

  int errors        = 0;
  int items_queued  = 0;
  int loads_done    = 0;
  int queries_done  = 0;
  int results_seen  = 0;
  int cfg_writes    = 0;
  int outcome_cnt [3] = '{0, 0, 0};

  string chan_name [NCHAN] = '{"red", "green", "blue", "alpha"};

  // Ramp evaluation: scan the first n stops for one at or above the point,
  // clamp at either end, else interpolate with a truncated Q0.16 fraction.
  function automatic ramp_out_t ramp_eval(input logic signed [POS_W-1:0] t);
    ramp_out_t r;
    int        n;
    int        i;
    longint    pa;
    longint    pb;
    longint    f;
    longint    va;
    longint    vb;
    // a count of 0 acts as 1, counts past the table act as the table depth
    if (ramp_count == 0)
      n = 1;
    else if (ramp_count > TBL_DEPTH)
      n = TBL_DEPTH;
    else
      n = ramp_count;
    i = 0;
    while (i < n && tbl_pos[i] < t)
      i++;
    if (i == 0) begin
      r.code  = CL_LOW;
      r.chans = tbl_val[0];
    end else if (i == n) begin
      r.code  = CL_HIGH;
      r.chans = tbl_val[n-1];
    end else begin
      // every stop before i lies below t, so pb - pa is positive
      pa = tbl_pos[i-1];
      pb = tbl_pos[i];
      f  = ((longint'(t) - pa) <<< 16) / (pb - pa);
      if (f > 65536)
        f = 65536;
      r.code = CL_INTERP;
      for (int ch = 0; ch < NCHAN; ch++) begin
        va = tbl_val[i-1][ch];
        vb = tbl_val[i][ch];
        r.chans[ch] = 16'((va * (65536 - f) + vb * f) >>> 16);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, holds the payload while stalled, and
  // draws a random idle gap after each accepted request. Now and then it
  // switches into a steady mode with no gaps at all.
  // ---------------------------------------------------------------------------
  ramp_req_t cur_req;
  int        tx_gap    = 0;
  bit        tx_steady = 1'b0;
  bit        tx_free;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_free = !in_valid;
      if (in_valid && !in_stall) begin
        // request accepted: apply it to the shadow table or predict a result
        if (cur_req.op == OP_LOAD) begin
          tbl_pos[cur_req.idx] = cur_req.pos;
          tbl_val[cur_req.idx] = cur_req.vals;
          loads_done++;
        end else begin
          ramp_expect_q = {ramp_expect_q, ramp_eval(cur_req.point)};
          outcome_cnt[ramp_expect_q[$].code]++;
          queries_done++;
        end
        tx_free = 1'b1;
        tx_gap  = tx_steady ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0)
          tx_steady = !tx_steady;
      end
      if (tx_free) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (req_pending_q.size() != 0) begin
          cur_req = req_pending_q.pop_front();
          opcode        <= cur_req.op;
          stop_index    <= cur_req.idx;
          stop_position <= cur_req.pos;
          value_red     <= cur_req.vals[0];
          value_green   <= cur_req.vals[1];
          value_blue    <= cur_req.vals[2];
          value_alpha   <= cur_req.vals[3];
          query_point   <= cur_req.point;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // stalls for a random spell after each one. Twice in the run it holds off for a
  // long stretch so the block fills and pushes back on its input.
  // ---------------------------------------------------------------------------
  ramp_out_t want_res;
  int        rx_wait   = 0;
  int        hold_left = 0;
  bit        rx_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (ramp_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d a=%0d clamp=%0d",
                   $time, out_red, out_green, out_blue, out_alpha, clamped_end);
          errors++;
        end else begin
          want_res = ramp_expect_q.pop_front();
          for (int ch = 0; ch < NCHAN; ch++) begin
            if (out_chans[ch] !== want_res.chans[ch]) begin
              $display("%0t: %s mismatch: expected %0d, actual %0d",
                       $time, chan_name[ch], want_res.chans[ch], out_chans[ch]);
              errors++;
            end
          end
          if (clamped_end !== want_res.code) begin
            $display("%0t: clamped_end mismatch: expected %0d, actual %0d",
                     $time, want_res.code, clamped_end);
            errors++;
          end
        end
        rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0)
          rx_steady = !rx_steady;
        if (results_seen == 150 || results_seen == 1100)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // channel value biased toward 0, one, all ones and the Q1.15 range
  function automatic chans_t rand_chans();
    chans_t v;
    for (int ch = 0; ch < NCHAN; ch++) begin
      case ($urandom_range(0, 7))
        0:       v[ch] = 16'h0000;
        1:       v[ch] = 16'h8000;
        2:       v[ch] = 16'hFFFF;
        3, 4, 5: v[ch] = 16'($urandom_range(0, 32768));
        default: v[ch] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  // load request; the unused query point gets random bits
  task automatic push_stop(input int idx, input int pos, input chans_t vals);
    ramp_req_t r;
    r.op    = OP_LOAD;
    r.idx   = IDX_W'(idx);
    r.pos   = POS_W'(pos);
    r.vals  = vals;
    r.point = POS_W'($urandom);
    req_pending_q = {req_pending_q, r};
    items_queued++;
  endtask

  // query request; the unused load fields get random bits
  task automatic push_query(input int point);
    ramp_req_t r;
    r.op    = OP_QUERY;
    r.idx   = IDX_W'($urandom);
    r.pos   = POS_W'($urandom);
    r.vals  = {$urandom, $urandom};
    r.point = POS_W'(point);
    req_pending_q = {req_pending_q, r};
    items_queued++;
  endtask

  // wait until every request is in and every result is out, then let
  // trailing loads (which give no result) finish inside the block
  task automatic wait_ramp_idle();
    @(negedge clk);
    while (req_pending_q.size() != 0 || in_valid || ramp_expect_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_stop_count(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ramp_count  = v;
    cfg_writes++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests, then random phases. Each phase sets
  // the stop count while idle, reloads the table and runs mostly queries.
  // ---------------------------------------------------------------------------
  initial begin : stim
    int p [TBL_DEPTH];
    int tmp;
    int j;
    int lo;
    int hi;
    int pt;
    int base;
    int mode;
    int ph;
    int cnt;
    bit sorted_tbl;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: whole table loaded first so no query ever reads an unwritten
    // entry. Extreme positions at both ends, two close stops in the middle.
    push_stop(0, -8388608, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
    push_stop(1, -1000,    {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    push_stop(2, 0,        {16'h0000, 16'hFFFF, 16'h8000, 16'h1234});
    push_stop(3, 256,      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    push_stop(4, 300,      {16'h7FFF, 16'h4000, 16'hFFFF, 16'h0000});
    push_stop(5, 301,      {16'h0001, 16'h8001, 16'h5555, 16'hAAAA});
    push_stop(6, 100000,   rand_chans());
    push_stop(7, 8388607,  {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    // reset count of one: at the only stop, then past it
    push_query(-8388608);
    push_query(0);
    wait_ramp_idle();

    // full table: at the first stop, just above it, exactly at inner stops
    // (fraction of one), between stops, and the far end of the range
    write_stop_count(4'd8);
    push_query(-8388608);
    push_query(-8388607);
    push_query(-1000);
    push_query(-999);
    push_query(0);
    push_query(128);
    push_query(300);
    push_query(301);
    push_query(8388606);
    push_query(8388607);
    wait_ramp_idle();

    // short table: above the last stop in use, at the first stop and between stops
    write_stop_count(4'd3);
    push_query(1);
    push_query(-8388608);
    push_query(-500);

    ph = 0;
    while (items_queued < ITEMS_TOTAL) begin
      wait_ramp_idle();
      case (ph)
        0:       cnt = 8;
        1:       cnt = 0;
        2:       cnt = 15;
        3:       cnt = 1;
        4:       cnt = 2;
        5:       cnt = 8;
        default: cnt = $urandom_range(0, 15);
      endcase
      write_stop_count(CNT_W'(cnt));

      // stop positions: full range, a narrow cluster, or a wider window
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 200000) - 100000;
      for (int k = 0; k < TBL_DEPTH; k++) begin
        if (mode == 0)
          p[k] = $signed($urandom) >>> 8;
        else if (mode == 1)
          p[k] = base + $urandom_range(0, 2000);
        else
          p[k] = base + $urandom_range(0, 1 << 20);
      end
      for (int a = 0; a < TBL_DEPTH - 1; a++) begin
        for (int b = 0; b < TBL_DEPTH - 1 - a; b++) begin
          if (p[b] > p[b+1]) begin
            tmp    = p[b];
            p[b]   = p[b+1];
            p[b+1] = tmp;
          end
        end
      end
      lo = p[0];
      hi = p[TBL_DEPTH-1];

      // most phases keep the table sorted; the rest scramble it
      sorted_tbl = ($urandom_range(0, 4) != 0);
      if (!sorted_tbl) begin
        for (int k = 0; k < TBL_DEPTH; k++) begin
          j    = $urandom_range(0, TBL_DEPTH - 1);
          tmp  = p[k];
          p[k] = p[j];
          p[j] = tmp;
        end
      end
      for (int k = 0; k < TBL_DEPTH; k++)
        push_stop(k, p[k], rand_chans());

      for (int q = 0; q < 90; q++) begin
        if ($urandom_range(0, 19) == 0) begin
          // stray load in the middle of the queries
          push_stop($urandom_range(0, TBL_DEPTH - 1), lo + $urandom_range(0, hi - lo),
                    rand_chans());
        end else begin
          case ($urandom_range(0, 9))
            0:       pt = p[$urandom_range(0, TBL_DEPTH - 1)];
            1:       pt = $signed($urandom) >>> 8;
            2:       pt = p[$urandom_range(0, TBL_DEPTH - 1)] + $urandom_range(0, 2) - 1;
            default: pt = lo - 64 + $urandom_range(0, hi - lo + 128);
          endcase
          if (pt > 8388607)
            pt = 8388607;
          if (pt < -8388608)
            pt = -8388608;
          push_query(pt);
        end
      end
      ph++;
    end

    wait_ramp_idle();
    $display("Covered %0d loads and %0d queries over %0d count writes; %0d results seen.",
             loads_done, queries_done, cfg_writes, results_seen);
    $display("Query outcomes: %0d interpolated, %0d clamped low, %0d clamped high.",
             outcome_cnt[CL_INTERP], outcome_cnt[CL_LOW], outcome_cnt[CL_HIGH]);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // hard stop in case the block hangs or a result never arrives
  initial begin
    #(RUN_LIMIT);
    $display("Timeout: %0d results still expected, %0d requests not sent",
             ramp_expect_q.size(), req_pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/plr_pkg.sv
rtl/plr_ram.sv
rtl/plr_fifo.sv
rtl/plr_front.sv
rtl/plr_back.sv
rtl/piecewise_linear_ramp_lookup_top.sv
rtl/plr_checker.sv
bench/tb_top.sv
